// ===== hdl/tsd_pkg.sv =====
// Shared types and constants for the touch swipe detector.
// Request, result, command and configuration structs, plus codes.
// No dependencies.
package tsd_pkg;

    localparam int COORD_W        = 16;
    localparam int CNT_W          = 10;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 16;
    localparam int QUEUE_DEPTH    = 2;
    localparam int HOLDOFF_MS_DEF = 3000;
    localparam int COORD_BITS_DEF = 16;

    // request mode codes
    localparam logic [2:0] MODE_TICK  = 3'd0;
    localparam logic [2:0] MODE_START = 3'd1;
    localparam logic [2:0] MODE_X     = 3'd2;
    localparam logic [2:0] MODE_Y     = 3'd3;
    localparam logic [2:0] MODE_END   = 3'd4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLED     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIENTATION = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_X_MAX       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_MAX       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_START_RANGE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MOVE_LENGTH = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_ARRAY_SIZE  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP_MS      = 3'd7;

    // display orientation codes
    localparam logic [1:0] ORIENT_LANDSCAPE    = 2'd0;
    localparam logic [1:0] ORIENT_PORTRAIT     = 2'd1;
    localparam logic [1:0] ORIENT_LANDSCAPE180 = 2'd2;
    localparam logic [1:0] ORIENT_PORTRAIT270  = 2'd3;

    localparam logic [CNT_W-1:0] ARRAY_MIN = 10'd30;
    localparam logic [CNT_W-1:0] ARRAY_MAX = 10'd1000;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_TICK,
        OP_START,
        OP_SAMPLE_X,
        OP_SAMPLE_Y,
        OP_END
    } op_t;

    typedef struct packed {
        logic [2:0]         mode;
        logic [COORD_W-1:0] coord;
        logic [COORD_W-1:0] start_y;
        logic               screen_busy;
    } in_t;

    typedef struct packed {
        logic swipe_seen;
        logic open_menu;
    } out_t;

    typedef struct packed {
        op_t                op;
        logic [COORD_W-1:0] coord;
        logic [COORD_W-1:0] start_y;
        logic               busy;
    } cmd_t;

    typedef struct packed {
        logic               enabled;
        logic [1:0]         orientation;
        logic [COORD_W-1:0] x_max;
        logic [COORD_W-1:0] y_max;
        logic [COORD_W-1:0] start_range;
        logic [CNT_W-1:0]   move_length;
        logic [CNT_W-1:0]   array_size;
        logic [COORD_W-1:0] gap_ms;
    } cfg_t;

endpackage

// ===== hdl/touch_swipe_detector.sv =====
// Top level of the touch edge-swipe detector: config registers, front, queue, back.
// Depends on tsd_pkg, tsd_front, tsd_queue, tsd_back.
//
//  channel   ports                          carries
//  s_        s_valid/s_ready/s_data (in_t)  touch request: mode, coord, start_y, busy
//  m_        m_valid/m_ready/m_data (out_t) one result per request: swipe_seen, open_menu
//  cfg_      cfg_wr_en/cfg_index/cfg_wdata  register write, no wait, no read-back
//
// One request per cycle sustained while m_ready is high; a request is stored in the two-entry queue
// and its result is registered as it leaves, so m_valid rises after the queue and the result register.
// Rate is set by the back end, which retires one command per cycle unless m_ stalls.
// aresetn (synchronous) clears registers to their defaults, axis state to zero,
// the gap timer to saturated and the holdoff timer to zero.
// A stall on m_ stops the back end; the queue then fills and drops s_ready.
module touch_swipe_detector import tsd_pkg::*; #(
    parameter int HOLDOFF_MS = HOLDOFF_MS_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_t                   s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_t                  m_data,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    cfg_t cfg_reg, cfg_next;
    cmd_t front_cmd;
    cmd_t q_head;
    logic q_full;
    logic q_nonempty;
    logic q_pop;

    // Configuration registers; the user must write them only while the block is idle, the block does not enforce it.
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_ENABLED:     cfg_next.enabled     = cfg_wdata[0];
                CFG_ORIENTATION: cfg_next.orientation = cfg_wdata[1:0];
                CFG_X_MAX:       cfg_next.x_max       = cfg_wdata;
                CFG_Y_MAX:       cfg_next.y_max       = cfg_wdata;
                CFG_START_RANGE: cfg_next.start_range = cfg_wdata;
                CFG_MOVE_LENGTH: cfg_next.move_length = cfg_wdata[CNT_W-1:0];
                CFG_ARRAY_SIZE:  cfg_next.array_size  = cfg_wdata[CNT_W-1:0];
                CFG_GAP_MS:      cfg_next.gap_ms      = cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.enabled     <= 1'b0;
            cfg_reg.orientation <= ORIENT_LANDSCAPE;
            cfg_reg.x_max       <= 16'd1023;
            cfg_reg.y_max       <= 16'd767;
            cfg_reg.start_range <= 16'd34;
            cfg_reg.move_length <= 10'd10;
            cfg_reg.array_size  <= 10'd60;
            cfg_reg.gap_ms      <= 16'd250;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // Front: decode, mask coordinates, turn requests other than ticks into no-ops while disabled.
    tsd_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .in_data (s_data),
        .enabled (cfg_reg.enabled),
        .cmd     (front_cmd)
    );

    // Decoupling queue: s_ready only depends on queue occupancy.
    assign s_ready = !q_full;

    tsd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (s_valid),
        .push_data (front_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .nonempty  (q_nonempty),
        .head      (q_head)
    );

    // Back: stateful tracking and the result register.
    tsd_back #(
        .HOLDOFF_MS (HOLDOFF_MS),
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .cmd_valid (q_nonempty),
        .cmd       (q_head),
        .cmd_pop   (q_pop),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

// ===== hdl/tsd_front.sv =====
// Front end: classifies each request into a back-end command.
// Depends on tsd_pkg.
module tsd_front import tsd_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  in_t  in_data,
    input  logic enabled,
    output cmd_t cmd
);

    localparam logic [COORD_W-1:0] COORD_MASK = {COORD_W{1'b1}} >> (COORD_W - COORD_BITS);

    always_comb begin
        cmd.coord   = in_data.coord & COORD_MASK;
        cmd.start_y = in_data.start_y & COORD_MASK;
        cmd.busy    = in_data.screen_busy;
        unique case (in_data.mode)
            MODE_TICK:  cmd.op = OP_TICK;
            MODE_START: cmd.op = enabled ? OP_START : OP_NOP;
            MODE_X:     cmd.op = enabled ? OP_SAMPLE_X : OP_NOP;
            MODE_Y:     cmd.op = enabled ? OP_SAMPLE_Y : OP_NOP;
            MODE_END:   cmd.op = enabled ? OP_END : OP_NOP;
            default:    cmd.op = OP_NOP;   // unused modes
        endcase
    end

endmodule

// ===== hdl/tsd_queue.sv =====
// Short command queue between front and back ends.
// Depends on tsd_pkg.
module tsd_queue import tsd_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  cmd_t push_data,
    output logic full,
    input  logic pop,
    output logic nonempty,
    output cmd_t head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_QW = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_QW-1:0] DEPTH_C = CNT_QW'(DEPTH);

    cmd_t              mem [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_QW-1:0] count_reg, count_next;
    logic              do_push, do_pop;

    assign full     = (count_reg == DEPTH_C);
    assign nonempty = (count_reg != '0);
    assign head     = mem[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && nonempty;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== hdl/tsd_back.sv =====
// Back end: per-axis tracking, timers, swipe check and result register.
// Depends on tsd_pkg.
module tsd_back import tsd_pkg::*; #(
    parameter int HOLDOFF_MS = HOLDOFF_MS_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic aclk,
    input  logic aresetn,
    input  cfg_t cfg,
    input  logic cmd_valid,
    input  cmd_t cmd,
    output logic cmd_pop,
    output logic m_valid,
    input  logic m_ready,
    output out_t m_data
);

    localparam int OPEN_W = $clog2(HOLDOFF_MS + 1);
    localparam logic [OPEN_W-1:0] HOLDOFF_C = OPEN_W'(HOLDOFF_MS);
    localparam logic [CNT_W-1:0]  CNT_MAX   = {CNT_W{1'b1}};

    logic [COORD_BITS-1:0] first_reg   [2], first_next   [2];
    logic [COORD_BITS-1:0] second_reg  [2], second_next  [2];
    logic [COORD_BITS-1:0] prev_reg    [2], prev_next    [2];
    logic [COORD_BITS-1:0] extreme_reg [2], extreme_next [2];
    logic [CNT_W-1:0]      trend_reg   [2], trend_next   [2];
    logic [CNT_W-1:0]      index_reg   [2], index_next   [2];
    logic [COORD_W-1:0]    ms_report_reg, ms_report_next;
    logic [OPEN_W-1:0]     ms_open_reg, ms_open_next;
    logic                  m_valid_reg, m_valid_next;
    out_t                  m_data_reg, m_data_next;

    logic                  ax;
    logic                  down;
    logic [CNT_W-1:0]      size_m1;
    logic [COORD_BITS-1:0] samp;
    logic [COORD_BITS-1:0] v;
    logic                  new_ext;
    logic                  sw_ax;
    logic [COORD_W:0]      span;
    logic                  swipe;
    out_t                  res;

    assign cmd_pop = cmd_valid && (!m_valid_reg || m_ready);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // sample path
    always_comb begin
        ax   = (cmd.op == OP_SAMPLE_Y);
        down = (!ax && cfg.orientation == ORIENT_PORTRAIT) ||
               (ax && cfg.orientation == ORIENT_LANDSCAPE180);
        if (cfg.array_size < ARRAY_MIN) begin
            size_m1 = ARRAY_MIN - 1'b1;
        end else if (cfg.array_size > ARRAY_MAX) begin
            size_m1 = ARRAY_MAX - 1'b1;
        end else begin
            size_m1 = cfg.array_size - 1'b1;
        end
        samp = cmd.coord[COORD_BITS-1:0];
        v    = prev_reg[ax];
        if (down) begin
            new_ext = (v < second_reg[ax]) && (v < extreme_reg[ax]);
        end else begin
            new_ext = (v > second_reg[ax]) && (v > extreme_reg[ax]);
        end
    end

    // swipe check at report end
    always_comb begin
        sw_ax = (cfg.orientation == ORIENT_LANDSCAPE) ||
                (cfg.orientation == ORIENT_LANDSCAPE180);
        case (cfg.orientation)
            ORIENT_PORTRAIT:     span = {1'b0, cfg.x_max} - (COORD_W + 1)'(first_reg[sw_ax]);
            ORIENT_LANDSCAPE180: span = {1'b0, cfg.y_max} - (COORD_W + 1)'(first_reg[sw_ax]);
            default:             span = (COORD_W + 1)'(first_reg[sw_ax]);
        endcase
        swipe = (index_reg[sw_ax] >= cfg.move_length) &&
                ($signed(span) <= $signed({1'b0, cfg.start_range})) &&
                (trend_reg[sw_ax] > cfg.move_length);
    end

    always_comb begin
        first_next     = first_reg;
        second_next    = second_reg;
        prev_next      = prev_reg;
        extreme_next   = extreme_reg;
        trend_next     = trend_reg;
        index_next     = index_reg;
        ms_report_next = ms_report_reg;
        ms_open_next   = ms_open_reg;
        res            = '0;
        if (cmd_pop) begin
            unique case (cmd.op)
                OP_TICK: begin
                    if (ms_report_reg != {COORD_W{1'b1}}) begin
                        ms_report_next = ms_report_reg + 1'b1;
                    end
                    if (ms_open_reg != {OPEN_W{1'b1}}) begin
                        ms_open_next = ms_open_reg + 1'b1;
                    end
                end
                OP_START: begin
                    if (ms_report_reg > cfg.gap_ms) begin
                        index_next[0] = '0;
                        index_next[1] = '0;
                        prev_next[0]  = cmd.coord[COORD_BITS-1:0];
                        prev_next[1]  = cmd.start_y[COORD_BITS-1:0];
                    end
                end
                OP_SAMPLE_X, OP_SAMPLE_Y: begin
                    if (index_reg[ax] < size_m1) begin
                        if (index_reg[ax] >= 10'd2 && new_ext) begin
                            extreme_next[ax] = v;
                            if (trend_reg[ax] != CNT_MAX) begin
                                trend_next[ax] = trend_reg[ax] + 1'b1;
                            end
                        end
                        second_next[ax] = prev_reg[ax];
                        prev_next[ax]   = samp;
                        index_next[ax]  = index_reg[ax] + 1'b1;
                        // first sample of a gesture seeds the trend tracking
                        if (index_reg[ax] == '0) begin
                            first_next[ax]   = samp;
                            extreme_next[ax] = samp;
                            trend_next[ax]   = '0;
                        end
                    end
                end
                OP_END: begin
                    ms_report_next = '0;
                    if (swipe) begin
                        res.swipe_seen = 1'b1;
                        index_next[0]  = '0;
                        index_next[1]  = '0;
                        if (!cmd.busy && ms_open_reg >= HOLDOFF_C) begin
                            res.open_menu = 1'b1;
                            ms_open_next  = '0;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (cmd_pop) begin
            m_valid_next = 1'b1;
            m_data_next  = res;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 2; i++) begin
                first_reg[i]   <= '0;
                second_reg[i]  <= '0;
                prev_reg[i]    <= '0;
                extreme_reg[i] <= '0;
                trend_reg[i]   <= '0;
                index_reg[i]   <= '0;
            end
            ms_report_reg <= {COORD_W{1'b1}};
            ms_open_reg   <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            first_reg     <= first_next;
            second_reg    <= second_next;
            prev_reg      <= prev_next;
            extreme_reg   <= extreme_next;
            trend_reg     <= trend_next;
            index_reg     <= index_next;
            ms_report_reg <= ms_report_next;
            ms_open_reg   <= ms_open_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    a_index_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (index_reg[0] < ARRAY_MAX) && (index_reg[1] < ARRAY_MAX))
        else $error("axis index ran past the largest buffer");

    a_open_needs_swipe: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_data_reg.open_menu |-> m_data_reg.swipe_seen)
        else $error("menu opened without a swipe");

    a_open_clears_timer: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd_pop && res.open_menu |=> (ms_open_reg == '0) && m_data_reg.open_menu)
        else $error("open did not restart holdoff timer");

    a_end_clears_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd_pop && cmd.op == OP_END |=> ms_report_reg == '0)
        else $error("report end did not clear gap timer");

    a_swipe_clears_index: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd_pop && res.swipe_seen |=> (index_reg[0] == '0) && (index_reg[1] == '0))
        else $error("swipe left sample counts set");

endmodule
